// File: rtl/pbc_pkg.sv
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RAD_BITS    = COORD_BITS - 1;
  localparam int PT_BITS     = COORD_BITS + 1;
  localparam int DIFF_BITS   = COORD_BITS + 2;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int SQ_BITS     = PROD_BITS - 1;
  localparam int DV_BITS     = PROD_BITS + 2;
  localparam int VV_BITS     = PROD_BITS;
  localparam int HALF_BITS   = VV_BITS / 2;
  localparam int R2_BITS     = 2 * COORD_BITS;
  localparam int R2VV_BITS   = R2_BITS + VV_BITS;
  localparam int LHS_BITS    = 2 * VV_BITS;
  localparam int THIRD_BITS  = LHS_BITS / 3;
  localparam int CONEL_BITS  = LHS_BITS + VV_BITS;
  localparam int CONER_BITS  = LHS_BITS + R2_BITS;
  localparam int ADDR_BITS   = 3;
  localparam int LANE_STAGES = 9;
  // Input register, lane stages and the output register.
  localparam int NUM_STAGES  = LANE_STAGES + 2;
  localparam int IN_BYTES    = (6 * COORD_BITS + 7) / 8;
  localparam int IN_BITS     = 8 * IN_BYTES;
  localparam int OUT_BITS    = 8;

  typedef enum logic [1:0] {
    KIND_SPHERE,
    KIND_BOX,
    KIND_CYLINDER,
    KIND_CONE
  } kind_e;

  typedef enum logic [1:0] {
    CLASS_WHITE,
    CLASS_GRAY,
    CLASS_BLACK
  } class_e;

  typedef enum logic [ADDR_BITS-1:0] {
    REG_KIND,
    REG_AX,
    REG_AY,
    REG_AZ,
    REG_BX,
    REG_BY,
    REG_BZ,
    REG_RADIUS
  } reg_idx_e;

  typedef logic [PT_BITS-1:0]   pt_coord_t;
  typedef pt_coord_t [2:0]      point_t;
  typedef logic [DIFF_BITS-1:0] diff_t;
  typedef diff_t [2:0]          diff3_t;
  typedef logic [LANE_STAGES-1:0] lane_en_t;

  // Configuration and the values derived from it, as seen by each lane.
  typedef struct packed {
    kind_e                  kind;
    point_t                 a2;
    point_t                 b2;
    point_t                 org;
    diff3_t                 v;
    logic                   vv_zero;
    logic [VV_BITS-1:0]     vv;
    logic [R2_BITS-1:0]     r2;
    logic [R2VV_BITS-1:0]   r2vv;
  } cfg_t;

endpackage

// File: rtl/primitive_box_classifier.sv
`timescale 1ns / 1ps

// Classifies axis-aligned boxes against one configured solid (sphere, open
// box, cylinder or cone) by testing the min corner, max corner and midpoint.
// Input channel s_axis carries one box per transaction; output channel
// m_axis returns one class per box, in order: white, gray or black.
// The user must set the solid through the write port while no box is in
// flight; the block does not enforce this. Derived values settle in registers
// after a write, which the pipeline depth covers.
// Throughput: one box per cycle unless m_axis stalls; three point lanes run
// side by side, each a nine-stage chain of differences, dot products and
// split wide products. Every stage has a valid bit and holds when its
// successor is full and stalled, so a stalled receiver first lets empty
// stages fill and then deasserts s_axis_tready; nothing is lost or repeated.
// Reset clears the valid bits and zeroes the configuration but sets vv_zero.

module primitive_box_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pbc_pkg::ADDR_BITS-1:0]       cfg_addr_i,
  input  logic [pbc_pkg::COORD_BITS-1:0]      cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [pbc_pkg::IN_BITS-1:0]         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // node_class, then zero padding
  output logic [pbc_pkg::OUT_BITS-1:0]        m_axis_tdata
);

  localparam int N  = pbc_pkg::NUM_STAGES;
  localparam int CB = pbc_pkg::COORD_BITS;

  pbc_pkg::cfg_t cfg;

  pbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic [N-1:0] valid_q;
  logic [N:0]   ready;

  always_comb begin
    ready[N] = m_axis_tready;
    for (int k = N - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < N; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign s_axis_tready = ready[0];

  logic [2:0][CB-1:0] lo_q, hi_q;

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= s_axis_tdata[i*CB +: CB];
        hi_q[i] <= s_axis_tdata[(i+3)*CB +: CB];
      end
    end
  end

  // Coordinates are doubled so that the midpoint is the exact corner sum.
  pbc_pkg::point_t p_lo, p_hi, p_mid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_lo[i]  = {lo_q[i], 1'b0};
      p_hi[i]  = {hi_q[i], 1'b0};
      p_mid[i] = $signed({lo_q[i][CB-1], lo_q[i]}) + $signed({hi_q[i][CB-1], hi_q[i]});
    end
  end

  pbc_pkg::lane_en_t lane_en;
  logic [2:0]        pt_in;

  assign lane_en = ready[pbc_pkg::LANE_STAGES:1];

  pbc_lane u_lane_lo (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .p_i      (p_lo),
    .cfg_i    (cfg),
    .inside_o (pt_in[0])
  );

  pbc_lane u_lane_mid (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .p_i      (p_mid),
    .cfg_i    (cfg),
    .inside_o (pt_in[1])
  );

  pbc_lane u_lane_hi (
    .clk_i    (clk_i),
    .en_i     (lane_en),
    .p_i      (p_hi),
    .cfg_i    (cfg),
    .inside_o (pt_in[2])
  );

  pbc_pkg::class_e class_d, class_q;

  always_comb begin
    if (&pt_in)      class_d = pbc_pkg::CLASS_BLACK;
    else if (|pt_in) class_d = pbc_pkg::CLASS_GRAY;
    else             class_d = pbc_pkg::CLASS_WHITE;
  end

  always_ff @(posedge clk_i) begin
    if (ready[N-1]) class_q <= class_d;
  end

  assign m_axis_tvalid = valid_q[N-1];
  assign m_axis_tdata  = {{(pbc_pkg::OUT_BITS-2){1'b0}}, class_q};

  // Input stalls only when every stage holds a transaction.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_q))
    else $error("input stalled while the pipeline has an empty stage");

  a_last_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[N-2] && ready[N-1]) |=> m_axis_tvalid)
    else $error("transaction lost on its way into the output register");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[N-2] && ready[N-1] && (&pt_in)) |=> (class_q == pbc_pkg::CLASS_BLACK))
    else $error("all three points inside but class is not black");

endmodule

// File: rtl/pbc_cfg.sv
`timescale 1ns / 1ps

module pbc_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pbc_pkg::ADDR_BITS-1:0]         cfg_addr_i,
  input  logic [pbc_pkg::COORD_BITS-1:0]        cfg_wdata_i,
  output pbc_pkg::cfg_t                         cfg_o
);

  pbc_pkg::kind_e                          kind_q;
  logic [2:0][pbc_pkg::COORD_BITS-1:0]     a_q;
  logic [2:0][pbc_pkg::COORD_BITS-1:0]     b_q;
  logic [pbc_pkg::RAD_BITS-1:0]            radius_q;

  pbc_pkg::point_t                         a2, b2;
  pbc_pkg::point_t                         org_d, org_q;
  pbc_pkg::diff3_t                         v_d, v_q;
  logic [pbc_pkg::R2_BITS-1:0]             r2_d, r2_q;
  logic [pbc_pkg::VV_BITS-1:0]             vv_d, vv_q;
  logic                                    vv_zero_d, vv_zero_q;
  logic [pbc_pkg::R2VV_BITS-1:0]           r2vv_d, r2vv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= pbc_pkg::KIND_SPHERE;
      a_q      <= '0;
      b_q      <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      case (pbc_pkg::reg_idx_e'(cfg_addr_i))
        pbc_pkg::REG_KIND:   kind_q   <= pbc_pkg::kind_e'(cfg_wdata_i[1:0]);
        pbc_pkg::REG_AX:     a_q[0]   <= cfg_wdata_i;
        pbc_pkg::REG_AY:     a_q[1]   <= cfg_wdata_i;
        pbc_pkg::REG_AZ:     a_q[2]   <= cfg_wdata_i;
        pbc_pkg::REG_BX:     b_q[0]   <= cfg_wdata_i;
        pbc_pkg::REG_BY:     b_q[1]   <= cfg_wdata_i;
        pbc_pkg::REG_BZ:     b_q[2]   <= cfg_wdata_i;
        pbc_pkg::REG_RADIUS: radius_q <= cfg_wdata_i[pbc_pkg::RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Derived values settle after a write: org, v and r2, then vv, then r2vv;
  // each lane stage reads only values settled by the time an item gets there.
  always_comb begin
    logic [pbc_pkg::COORD_BITS-1:0]     rad2;
    logic signed [pbc_pkg::PROD_BITS-1:0] sq;
    vv_d = '0;
    for (int i = 0; i < 3; i++) begin
      a2[i] = {a_q[i], 1'b0};
      b2[i] = {b_q[i], 1'b0};
    end
    // The cone axis runs from the vertex (point b) to the base.
    for (int i = 0; i < 3; i++) begin
      if (kind_q == pbc_pkg::KIND_CONE) begin
        org_d[i] = b2[i];
        v_d[i]   = $signed({a2[i][pbc_pkg::PT_BITS-1], a2[i]})
                 - $signed({b2[i][pbc_pkg::PT_BITS-1], b2[i]});
      end else begin
        org_d[i] = a2[i];
        v_d[i]   = $signed({b2[i][pbc_pkg::PT_BITS-1], b2[i]})
                 - $signed({a2[i][pbc_pkg::PT_BITS-1], a2[i]});
      end
    end
    rad2 = {radius_q, 1'b0};
    r2_d = rad2 * rad2;
    for (int i = 0; i < 3; i++) begin
      sq   = $signed(v_q[i]) * $signed(v_q[i]);
      vv_d = vv_d + {1'b0, sq[pbc_pkg::SQ_BITS-1:0]};
    end
    vv_zero_d = (v_q == '0);
    r2vv_d    = r2_q * vv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q     <= '0;
      v_q       <= '0;
      r2_q      <= '0;
      vv_q      <= '0;
      vv_zero_q <= 1'b1;
      r2vv_q    <= '0;
    end else begin
      org_q     <= org_d;
      v_q       <= v_d;
      r2_q      <= r2_d;
      vv_q      <= vv_d;
      vv_zero_q <= vv_zero_d;
      r2vv_q    <= r2vv_d;
    end
  end

  assign cfg_o.kind    = kind_q;
  assign cfg_o.a2      = a2;
  assign cfg_o.b2      = b2;
  assign cfg_o.org     = org_q;
  assign cfg_o.v       = v_q;
  assign cfg_o.vv_zero = vv_zero_q;
  assign cfg_o.vv      = vv_q;
  assign cfg_o.r2      = r2_q;
  assign cfg_o.r2vv    = r2vv_q;

endmodule

// File: rtl/pbc_lane.sv
`timescale 1ns / 1ps

module pbc_lane (
  input  logic              clk_i,
  input  pbc_pkg::lane_en_t en_i,
  input  pbc_pkg::point_t   p_i,
  input  pbc_pkg::cfg_t     cfg_i,
  output logic              inside_o
);

  localparam int H = pbc_pkg::HALF_BITS;
  localparam int T = pbc_pkg::THIRD_BITS;

  // Stage 1: offset from the axis origin and the open-box test.
  pbc_pkg::diff3_t d1_d, d1_q;
  logic            box_d;
  logic            box1_q, box2_q, box3_q, box4_q, box5_q, box6_q, box7_q, box8_q;

  always_comb begin
    box_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = $signed({p_i[i][pbc_pkg::PT_BITS-1], p_i[i]})
              - $signed({cfg_i.org[i][pbc_pkg::PT_BITS-1], cfg_i.org[i]});
      if (!($signed(cfg_i.a2[i]) < $signed(p_i[i]) && $signed(p_i[i]) < $signed(cfg_i.b2[i])))
        box_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q   <= d1_d;
      box1_q <= box_d;
    end
  end

  // Stage 2: per-axis products.
  logic [2:0][pbc_pkg::PROD_BITS-1:0] dv2_d, dv2_q;
  logic [2:0][pbc_pkg::SQ_BITS-1:0]   dd2_d, dd2_q;

  always_comb begin
    logic signed [pbc_pkg::PROD_BITS-1:0] sq;
    for (int i = 0; i < 3; i++) begin
      dv2_d[i] = $signed(d1_q[i]) * $signed(cfg_i.v[i]);
      sq       = $signed(d1_q[i]) * $signed(d1_q[i]);
      dd2_d[i] = sq[pbc_pkg::SQ_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dv2_q  <= dv2_d;
      dd2_q  <= dd2_d;
      box2_q <= box1_q;
    end
  end

  // Stage 3: dot products.
  logic signed [pbc_pkg::DV_BITS-1:0] dv3_q;
  logic [pbc_pkg::VV_BITS-1:0]        dd3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dv3_q  <= $signed(dv2_q[0]) + $signed(dv2_q[1]) + $signed(dv2_q[2]);
      dd3_q  <= {1'b0, dd2_q[0]} + {1'b0, dd2_q[1]} + {1'b0, dd2_q[2]};
      box3_q <= box2_q;
    end
  end

  // Stage 4: sphere and segment tests, half products of dd*vv and dv*dv.
  // Once the segment test passes, dv is known to fit the width of vv.
  logic [pbc_pkg::VV_BITS-1:0]    dvu;
  logic                           sph4_q, sph5_q, sph6_q, sph7_q, sph8_q;
  logic                           seg4_q, seg5_q, seg6_q, seg7_q, seg8_q;
  logic [pbc_pkg::VV_BITS+H-1:0]  pdd_lo_q, pdd_hi_q, pdv_lo_q, pdv_hi_q;

  assign dvu = dv3_q[pbc_pkg::VV_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sph4_q   <= dd3_q < {{(pbc_pkg::VV_BITS-pbc_pkg::R2_BITS){1'b0}}, cfg_i.r2};
      seg4_q   <= !dv3_q[pbc_pkg::DV_BITS-1]
                  && (dv3_q <= $signed({2'b00, cfg_i.vv}));
      pdd_lo_q <= dd3_q * cfg_i.vv[H-1:0];
      pdd_hi_q <= dd3_q * cfg_i.vv[pbc_pkg::VV_BITS-1:H];
      pdv_lo_q <= dvu * dvu[H-1:0];
      pdv_hi_q <= dvu * dvu[pbc_pkg::VV_BITS-1:H];
      box4_q   <= box3_q;
    end
  end

  // Stage 5: assemble the full products.
  logic [pbc_pkg::LHS_BITS-1:0] ddvv5_q, dvdv5_q, dvdv6_q, lhs6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      ddvv5_q <= {{H{1'b0}}, pdd_lo_q} + {pdd_hi_q, {H{1'b0}}};
      dvdv5_q <= {{H{1'b0}}, pdv_lo_q} + {pdv_hi_q, {H{1'b0}}};
      sph5_q  <= sph4_q;
      seg5_q  <= seg4_q;
      box5_q  <= box4_q;
    end
  end

  // Stage 6: squared distance to the axis, scaled by vv.
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      lhs6_q  <= ddvv5_q - dvdv5_q;
      dvdv6_q <= dvdv5_q;
      sph6_q  <= sph5_q;
      seg6_q  <= seg5_q;
      box6_q  <= box5_q;
    end
  end

  // Stage 7: cylinder compare and third products for the cone.
  logic                                 cyl7_q, cyl8_q;
  logic [2:0][T+pbc_pkg::VV_BITS-1:0]   plv_q;
  logic [2:0][T+pbc_pkg::R2_BITS-1:0]   pdr_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      cyl7_q <= lhs6_q <= {{(pbc_pkg::LHS_BITS-pbc_pkg::R2VV_BITS){1'b0}}, cfg_i.r2vv};
      for (int i = 0; i < 3; i++) begin
        plv_q[i] <= lhs6_q[i*T +: T] * cfg_i.vv;
        pdr_q[i] <= dvdv6_q[i*T +: T] * cfg_i.r2;
      end
      sph7_q <= sph6_q;
      seg7_q <= seg6_q;
      box7_q <= box6_q;
    end
  end

  // Stage 8: assemble the cone products.
  logic [pbc_pkg::CONEL_BITS-1:0] lvv8_q;
  logic [pbc_pkg::CONER_BITS-1:0] dr8_q;

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      lvv8_q <= {{(2*T){1'b0}}, plv_q[0]} + {{T{1'b0}}, plv_q[1], {T{1'b0}}}
              + {plv_q[2], {(2*T){1'b0}}};
      dr8_q  <= {{(2*T){1'b0}}, pdr_q[0]} + {{T{1'b0}}, pdr_q[1], {T{1'b0}}}
              + {pdr_q[2], {(2*T){1'b0}}};
      cyl8_q <= cyl7_q;
      sph8_q <= sph7_q;
      seg8_q <= seg7_q;
      box8_q <= box7_q;
    end
  end

  // Stage 9: pick the test of the configured solid.
  logic in_d, inside9_q;

  always_comb begin
    case (cfg_i.kind)
      pbc_pkg::KIND_SPHERE:   in_d = sph8_q;
      pbc_pkg::KIND_BOX:      in_d = box8_q;
      pbc_pkg::KIND_CYLINDER: in_d = !cfg_i.vv_zero && seg8_q && cyl8_q;
      pbc_pkg::KIND_CONE: in_d = !cfg_i.vv_zero && seg8_q
                                 && (lvv8_q <= {{(pbc_pkg::CONEL_BITS-pbc_pkg::CONER_BITS){1'b0}},
                                                dr8_q});
      default:                in_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) inside9_q <= in_d;
  end

  assign inside_o = inside9_q;

endmodule
